// ===== sv/gccrc_pkg.sv =====
`default_nettype none
package gccrc_pkg;

    // default sizing
    localparam int MAX_SITES_DEF  = 256;
    localparam int COORD_BITS_DEF = 20;
    localparam int MAX_CELLS_DEF  = 1024;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_IDX = 2'd3;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_CELL_WIDTH_X = 3'd2;
    localparam logic [2:0] REG_CELL_WIDTH_Y = 3'd3;
    localparam logic [2:0] REG_CELLS_X      = 3'd4;
    localparam logic [2:0] REG_CELLS_Y      = 3'd5;
    localparam logic [2:0] REG_COVER_RANGE  = 3'd6;

    // field and register widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int ORG_W    = 20;
    localparam int WID_W    = 16;
    localparam int CELLS_W  = 11;
    localparam int RANGE_W  = 19;

    // derived datapath widths
    localparam int MUL_W    = CELLS_W + WID_W;     // (2*idx+1)*width, cells*width
    localparam int CENTER_W = MUL_W + 2;           // 2*origin + product, signed
    localparam int R2_W     = RANGE_W + 1;         // doubled radius
    localparam int LIM_W    = 2 * R2_W;            // squared doubled radius

    // reset values
    localparam logic signed [ORG_W-1:0] ORIGIN_RST = -20'sd16000;
    localparam logic [WID_W-1:0]        WIDTH_RST  = 16'd3200;
    localparam logic [CELLS_W-1:0]      CELLS_RST  = 11'd10;
    localparam logic [RANGE_W-1:0]      RANGE_RST  = 19'd1600;

endpackage
`default_nettype wire

// ===== sv/gccrc_cell.sv =====
`default_nettype none
// One storage cell of the site ring: holds one packed position and
// passes it to the next cell whenever the ring moves.
module gccrc_cell #(
    parameter int SITE_W = 2 * gccrc_pkg::COORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire logic [SITE_W-1:0] i_d,
    output logic      [SITE_W-1:0] o_q
);

    logic [SITE_W-1:0] r_q;

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ===== sv/gccrc_dist.sv =====
`default_nettype none
// Shared distance unit: one site per cycle, two register stages, hit
// flag from the final squared-distance compare.
module gccrc_dist #(
    parameter int COORD_BITS = gccrc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    input  wire logic signed [COORD_BITS-1:0]           i_site_x,
    input  wire logic signed [COORD_BITS-1:0]           i_site_y,
    input  wire logic signed [gccrc_pkg::CENTER_W-1:0]  i_cx,
    input  wire logic signed [gccrc_pkg::CENTER_W-1:0]  i_cy,
    input  wire logic [gccrc_pkg::R2_W-1:0]             i_r2,
    input  wire logic [gccrc_pkg::LIM_W-1:0]            i_lim,
    output logic                                        o_hit
);

    localparam int CEN_W = gccrc_pkg::CENTER_W;
    localparam int R2_W  = gccrc_pkg::R2_W;
    localparam int LIM_W = gccrc_pkg::LIM_W;
    localparam int DW    = ((COORD_BITS + 1 > CEN_W) ? COORD_BITS + 1 : CEN_W) + 1;

    logic signed [DW-1:0] w_dfx, w_dfy;
    logic [DW-1:0]        w_adx, w_ady;
    logic                 w_near;

    logic              r_ok1;
    logic [R2_W-1:0]   r_dx, r_dy;
    logic              r_ok2;
    logic [LIM_W-1:0]  r_sqx, r_sqy;

    // stage 1: doubled site minus doubled center, magnitude, box test
    always_comb begin
        w_dfx  = (DW'(i_site_x) <<< 1) - DW'(i_cx);
        w_dfy  = (DW'(i_site_y) <<< 1) - DW'(i_cy);
        w_adx  = w_dfx[DW-1] ? DW'(-w_dfx) : DW'(w_dfx);
        w_ady  = w_dfy[DW-1] ? DW'(-w_dfy) : DW'(w_dfy);
        w_near = (w_adx <= DW'(i_r2)) && (w_ady <= DW'(i_r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok1 <= 1'b0;
            r_ok2 <= 1'b0;
        end else begin
            r_ok1 <= i_valid && w_near;
            r_ok2 <= r_ok1;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_dx  <= w_adx[R2_W-1:0];
        r_dy  <= w_ady[R2_W-1:0];
        r_sqx <= LIM_W'(r_dx) * LIM_W'(r_dx);
        r_sqy <= LIM_W'(r_dy) * LIM_W'(r_dy);
    end

    // final compare against the squared radius
    assign o_hit = r_ok2 &&
        (((LIM_W + 1)'(r_sqx) + (LIM_W + 1)'(r_sqy)) <= (LIM_W + 1)'(i_lim));

endmodule
`default_nettype wire

// ===== sv/grid_cell_radius_coverage_count.sv =====
// Fixed-radius coverage counter over a ring of stored transmitter sites.
// Input stream (i_s_*): one command per transfer: load a position, query a
// grid cell, or clear the store. Output stream (o_m_*): one result per
// command, status plus covered count. Configuration is written through
// i_cfg_wr_en / i_cfg_idx / i_cfg_wr_data; the user must do so only while
// the block is idle; the block does not enforce it. Load, clear and rejected
// queries pass the prepare, evaluate and done states. A valid query rotates
// the whole ring of MAX_SITES cells past the shared distance unit, one site
// per cycle, then drains its two stages in the drain state. The ring
// rotation sets the query rate; one command is in work at a time and the
// next is accepted once the current result is in the output register.
// Reset empties the store (count to zero), loads the default map and
// clears the output valid flag; site contents need no reset.
// When the receiver stalls, the result stays in the output register and
// a following command is still accepted; its result waits in the final
// state until the register is free.
`default_nettype none
module grid_cell_radius_coverage_count #(
    parameter int MAX_SITES  = gccrc_pkg::MAX_SITES_DEF,
    parameter int COORD_BITS = gccrc_pkg::COORD_BITS_DEF,
    parameter int MAX_CELLS  = gccrc_pkg::MAX_CELLS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // in tdata: command[2], pos_x[COORD_BITS], pos_y[COORD_BITS],
    //           cell_col[10], cell_row[10], zero pad
    input  wire logic                                        i_s_tvalid,
    output logic                                             o_s_tready,
    input  wire logic [((2*COORD_BITS+22+7)/8)*8-1:0]        i_s_tdata,
    // out tdata: status[2], covered_count[9], zero pad
    output logic                                             o_m_tvalid,
    input  wire logic                                        i_m_tready,
    output logic [15:0]                                      o_m_tdata,
    input  wire logic                                        i_cfg_wr_en,
    input  wire logic [gccrc_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  wire logic [gccrc_pkg::CFG_W-1:0]                 i_cfg_wr_data
);

    localparam int SITE_W   = 2 * COORD_BITS;
    localparam int K_W      = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int C_W      = $clog2(MAX_SITES + 1);
    localparam int KC_W     = C_W + 1;
    localparam int ORG_W    = gccrc_pkg::ORG_W;
    localparam int WID_W    = gccrc_pkg::WID_W;
    localparam int CELLS_W  = gccrc_pkg::CELLS_W;
    localparam int MUL_W    = gccrc_pkg::MUL_W;
    localparam int CEN_W    = gccrc_pkg::CENTER_W;
    localparam int R2_W     = gccrc_pkg::R2_W;
    localparam int LIM_W    = gccrc_pkg::LIM_W;
    localparam int IDX_W    = gccrc_pkg::IDX_W;
    localparam int CMD_W    = gccrc_pkg::CMD_W;
    localparam int EC_W     = CELLS_W + 2;
    localparam int WIDE     = ((COORD_BITS > MUL_W + 1) ? COORD_BITS : MUL_W + 1) + 2;
    localparam int OUT_USED = gccrc_pkg::STATUS_W + gccrc_pkg::COUNT_W;

    // tdata field offsets
    localparam int OFS_PX  = CMD_W;
    localparam int OFS_PY  = OFS_PX + COORD_BITS;
    localparam int OFS_COL = OFS_PY + COORD_BITS;
    localparam int OFS_ROW = OFS_COL + IDX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_QRUN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // configuration registers
    logic signed [ORG_W-1:0]           r_org_x, r_org_y;
    logic [WID_W-1:0]                  r_wid_x, r_wid_y;
    logic [CELLS_W-1:0]                r_cells_x, r_cells_y;
    logic [gccrc_pkg::RANGE_W-1:0]     r_range;

    // control
    logic [2:0]      r_state;
    logic [C_W-1:0]  r_count;
    logic [K_W-1:0]  r_k;
    logic            r_drain;
    logic [C_W-1:0]  r_acc;
    logic            r_m_valid;
    logic [15:0]     r_m_data;

    // latched command and precomputed terms
    logic [CMD_W-1:0]             r_cmd;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [IDX_W-1:0]             r_col, r_row;
    logic [MUL_W-1:0]             r_span_x, r_span_y;
    logic [MUL_W-1:0]             r_cmul_x, r_cmul_y;
    logic [LIM_W-1:0]             r_lim;
    logic                         r_bad_idx;
    logic signed [CEN_W-1:0]      r_cx, r_cy;
    logic [gccrc_pkg::STATUS_W-1:0] r_status;

    logic                  w_s_xfer;
    logic [CELLS_W-1:0]    w_eff_x, w_eff_y;
    logic [R2_W-1:0]       w_r2;
    logic signed [WIDE-1:0] w_px, w_py, w_ox, w_oy, w_top_x, w_top_y;
    logic                  w_in_map;
    logic                  w_full;
    logic                  w_load_shift;
    logic                  w_rotate;
    logic                  w_tap_valid;
    logic                  w_hit;
    logic                  w_out_free;
    logic [SITE_W-1:0]     w_cell_q [MAX_SITES];
    logic [SITE_W-1:0]     w_ring_in;

    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_m_valid || i_m_tready;

    // cell counts clamped to the grid limit
    always_comb begin
        w_eff_x = ({2'b00, r_cells_x} > EC_W'(MAX_CELLS)) ? CELLS_W'(MAX_CELLS) : r_cells_x;
        w_eff_y = ({2'b00, r_cells_y} > EC_W'(MAX_CELLS)) ? CELLS_W'(MAX_CELLS) : r_cells_y;
        w_r2    = {r_range, 1'b0};
    end

    // map bounds check for a load
    always_comb begin
        w_px     = WIDE'(r_px);
        w_py     = WIDE'(r_py);
        w_ox     = WIDE'(r_org_x);
        w_oy     = WIDE'(r_org_y);
        w_top_x  = w_ox + $signed(WIDE'(r_span_x));
        w_top_y  = w_oy + $signed(WIDE'(r_span_y));
        w_in_map = (w_px >= w_ox) && (w_px < w_top_x) &&
                   (w_py >= w_oy) && (w_py < w_top_y);
        w_full   = (r_count >= C_W'(MAX_SITES));
    end

    assign w_load_shift = (r_state == S_EVAL) && (r_cmd == gccrc_pkg::CMD_LOAD) &&
                          w_in_map && !w_full;
    assign w_rotate     = (r_state == S_QRUN);
    // tap holds original cell MAX_SITES-1-k; stored entries sit in cells below count
    assign w_tap_valid  = w_rotate &&
                          ((KC_W'(r_k) + KC_W'(r_count)) >= KC_W'(MAX_SITES));

    // site ring: new loads enter cell 0, rotation feeds the last cell back
    assign w_ring_in = w_load_shift ? {r_py, r_px} : w_cell_q[MAX_SITES-1];

    for (genvar g = 0; g < MAX_SITES; g++) begin : g_ring
        gccrc_cell #(
            .SITE_W (SITE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_load_shift || w_rotate),
            .i_d     ((g == 0) ? w_ring_in : w_cell_q[(g == 0) ? 0 : g - 1]),
            .o_q     (w_cell_q[g])
        );
    end

    gccrc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_tap_valid),
        .i_site_x (w_cell_q[MAX_SITES-1][COORD_BITS-1:0]),
        .i_site_y (w_cell_q[MAX_SITES-1][SITE_W-1:COORD_BITS]),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_r2     (w_r2),
        .i_lim    (r_lim),
        .o_hit    (w_hit)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= gccrc_pkg::ORIGIN_RST;
            r_org_y   <= gccrc_pkg::ORIGIN_RST;
            r_wid_x   <= gccrc_pkg::WIDTH_RST;
            r_wid_y   <= gccrc_pkg::WIDTH_RST;
            r_cells_x <= gccrc_pkg::CELLS_RST;
            r_cells_y <= gccrc_pkg::CELLS_RST;
            r_range   <= gccrc_pkg::RANGE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                gccrc_pkg::REG_ORIGIN_X:     r_org_x   <= i_cfg_wr_data[ORG_W-1:0];
                gccrc_pkg::REG_ORIGIN_Y:     r_org_y   <= i_cfg_wr_data[ORG_W-1:0];
                gccrc_pkg::REG_CELL_WIDTH_X: r_wid_x   <= i_cfg_wr_data[WID_W-1:0];
                gccrc_pkg::REG_CELL_WIDTH_Y: r_wid_y   <= i_cfg_wr_data[WID_W-1:0];
                gccrc_pkg::REG_CELLS_X:      r_cells_x <= i_cfg_wr_data[CELLS_W-1:0];
                gccrc_pkg::REG_CELLS_Y:      r_cells_y <= i_cfg_wr_data[CELLS_W-1:0];
                gccrc_pkg::REG_COVER_RANGE:  r_range   <= i_cfg_wr_data[gccrc_pkg::RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // command latch and precompute (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_cmd <= i_s_tdata[CMD_W-1:0];
            r_px  <= i_s_tdata[OFS_PX +: COORD_BITS];
            r_py  <= i_s_tdata[OFS_PY +: COORD_BITS];
            r_col <= i_s_tdata[OFS_COL +: IDX_W];
            r_row <= i_s_tdata[OFS_ROW +: IDX_W];
        end
        if (r_state == S_PREP) begin
            r_span_x  <= MUL_W'(w_eff_x) * MUL_W'(r_wid_x);
            r_span_y  <= MUL_W'(w_eff_y) * MUL_W'(r_wid_y);
            r_cmul_x  <= MUL_W'({r_col, 1'b1}) * MUL_W'(r_wid_x);
            r_cmul_y  <= MUL_W'({r_row, 1'b1}) * MUL_W'(r_wid_y);
            r_lim     <= LIM_W'(w_r2) * LIM_W'(w_r2);
            r_bad_idx <= (CELLS_W'(r_col) >= w_eff_x) || (CELLS_W'(r_row) >= w_eff_y);
        end
        if (r_state == S_EVAL) begin
            r_cx <= (CEN_W'(r_org_x) <<< 1) + $signed(CEN_W'(r_cmul_x));
            r_cy <= (CEN_W'(r_org_y) <<< 1) + $signed(CEN_W'(r_cmul_y));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_drain   <= 1'b0;
            r_acc     <= '0;
            r_status  <= gccrc_pkg::ST_OK;
        end else begin
            // hit counter, cleared when a command is evaluated
            if (r_state == S_EVAL) begin
                r_acc <= '0;
            end else if (w_hit) begin
                r_acc <= r_acc + C_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_xfer) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    case (r_cmd)
                        gccrc_pkg::CMD_LOAD: begin
                            r_state <= S_DONE;
                            if (!w_in_map) begin
                                r_status <= gccrc_pkg::ST_OUTSIDE;
                            end else if (w_full) begin
                                r_status <= gccrc_pkg::ST_FULL;
                            end else begin
                                r_status <= gccrc_pkg::ST_OK;
                                r_count  <= r_count + C_W'(1);
                            end
                        end
                        gccrc_pkg::CMD_QUERY: begin
                            if (r_bad_idx) begin
                                r_status <= gccrc_pkg::ST_BAD_IDX;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= gccrc_pkg::ST_OK;
                                r_k      <= '0;
                                r_state  <= S_QRUN;
                            end
                        end
                        gccrc_pkg::CMD_CLEAR: begin
                            r_status <= gccrc_pkg::ST_OK;
                            r_count  <= '0;
                            r_state  <= S_DONE;
                        end
                        default: begin
                            r_status <= gccrc_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_QRUN: begin
                    r_k <= r_k + K_W'(1);
                    if (r_k == K_W'(MAX_SITES - 1)) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output valid: set when a result moves in, cleared when it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_m_data <= {(16 - OUT_USED)'(0), gccrc_pkg::COUNT_W'(r_acc), r_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
`default_nettype wire
